// File: rtl/sts_pkg.sv
// shared types and constants for section timing statistics
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;
    localparam int OPEN_DEPTH    = 16;
    localparam int SECTION_COUNT = 16;
    localparam int TIME_BITS     = 32;
    localparam int OPEN_AW = $clog2(OPEN_DEPTH);
    localparam int DEPTH_W = $clog2(OPEN_DEPTH + 1);
    localparam int SEC_AW  = $clog2(SECTION_COUNT);

    localparam logic [1:0] ST_ENTERED   = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_MATCHED   = 2'd2;
    localparam logic [1:0] ST_UNMATCHED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_SHIFT, S_STAT, S_SQUARE, S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic push;
        logic search_step;
        logic shift_step;
        logic stat_read;
        logic stat_write;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_exit;
        logic full;
        logic search_end;
        logic found;
        logic shift_end;
    } t_status;
endpackage
`default_nettype wire

// File: rtl/sts_ctrl.sv
// controller state machine for section timing statistics
// depends on sts_pkg
`timescale 1ns / 1ps
`default_nettype none
module sts_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  sts_pkg::t_status  i_stat,
    output logic              o_busy,
    output sts_pkg::t_cmd     o_cmd
);
    sts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sts_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            sts_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = sts_pkg::S_SEARCH;
                end
            end
            sts_pkg::S_SEARCH: begin
                if (!i_stat.is_exit) begin
                    o_cmd.push = !i_stat.full;
                    n_state = sts_pkg::S_DONE;
                end else if (i_stat.found) begin
                    n_state = sts_pkg::S_SHIFT;
                end else if (i_stat.search_end) begin
                    n_state = sts_pkg::S_DONE;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            sts_pkg::S_SHIFT: begin
                if (i_stat.shift_end) begin
                    o_cmd.stat_read = 1'b1;
                    n_state = sts_pkg::S_STAT;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            sts_pkg::S_STAT:   n_state = sts_pkg::S_SQUARE;
            sts_pkg::S_SQUARE: begin
                o_cmd.stat_write = 1'b1;
                n_state = sts_pkg::S_DONE;
            end
            sts_pkg::S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = sts_pkg::S_IDLE;
            end
            default: n_state = sts_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/sts_dp.sv
// datapath: open-section stack, per-section stats store, result registers
// depends on sts_pkg
`timescale 1ns / 1ps
`default_nettype none
module sts_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  sts_pkg::t_cmd     i_cmd,
    input  wire               i_command,
    input  wire  [3:0]        i_section_id,
    input  wire  [31:0]       i_timestamp,
    output sts_pkg::t_status  o_stat,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [3:0]        o_echo_id,
    output logic [31:0]       o_elapsed,
    output logic [31:0]       o_hit_count,
    output logic [47:0]       o_total_ticks,
    output logic [31:0]       o_min_ticks,
    output logic [31:0]       o_max_ticks,
    output logic [63:0]       o_square_sum
);
    localparam int TB = sts_pkg::TIME_BITS;
    localparam int OD = sts_pkg::OPEN_DEPTH;
    localparam int SC = sts_pkg::SECTION_COUNT;

    logic [3:0]    r_ids    [OD];
    logic [TB-1:0] r_starts [OD];
    logic [sts_pkg::DEPTH_W-1:0] r_depth;
    logic [sts_pkg::DEPTH_W-1:0] r_ptr;
    logic          r_cmd;
    logic [3:0]    r_id;
    logic [TB-1:0] r_now;
    logic [TB-1:0] r_elapsed;
    logic [1:0]    r_status;

    logic [SC-1:0] r_seen;
    logic [31:0]   r_cnt  [SC];
    logic [47:0]   r_tot  [SC];
    logic [31:0]   r_min  [SC];
    logic [31:0]   r_max  [SC];
    logic [63:0]   r_sq   [SC];
    logic [63:0]   r_prod;

    logic          id_in;
    logic [sts_pkg::SEC_AW-1:0] sidx;
    logic [sts_pkg::OPEN_AW-1:0] pidx, pnext;
    logic          hit;
    logic [31:0]   e32;
    logic [47:0]   tot_sum;
    logic [64:0]   sq_sum;

    assign id_in = ({28'd0, r_id} < 32'(SC));
    assign sidx  = sts_pkg::SEC_AW'(r_id);
    assign pidx  = sts_pkg::OPEN_AW'(r_ptr - 1'b1);
    assign pnext = sts_pkg::OPEN_AW'(r_ptr + 1'b1);
    assign hit   = (r_ptr != '0) && (r_ids[pidx] == r_id);
    assign e32   = 32'(r_elapsed);
    assign tot_sum = r_tot[sidx] + {16'd0, e32};
    assign sq_sum  = {1'b0, r_sq[sidx]} + {1'b0, r_prod};

    assign o_stat.is_exit    = r_cmd;
    assign o_stat.full       = (r_depth >= sts_pkg::DEPTH_W'(OD));
    assign o_stat.search_end = (r_ptr == '0);
    assign o_stat.found      = hit;
    assign o_stat.shift_end  = (r_ptr + 1'b1 >= r_depth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_seen  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.push) r_depth <= r_depth + 1'b1;
            if (i_cmd.stat_read) r_depth <= r_depth - 1'b1;
            if (i_cmd.stat_write && id_in) r_seen[sidx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= i_command;
            r_id      <= i_section_id;
            r_now     <= i_timestamp[TB-1:0];
            r_ptr     <= r_depth;
            r_elapsed <= '0;
            r_status  <= i_command ? sts_pkg::ST_UNMATCHED : sts_pkg::ST_ENTERED;
        end else if (!r_cmd && o_stat.full) begin
            r_status <= sts_pkg::ST_FULL;
        end
        if (i_cmd.push) begin
            r_ids[sts_pkg::OPEN_AW'(r_depth)]    <= r_id;
            r_starts[sts_pkg::OPEN_AW'(r_depth)] <= r_now;
        end
        if (i_cmd.search_step) r_ptr <= r_ptr - 1'b1;
        if (r_cmd && hit && r_status == sts_pkg::ST_UNMATCHED) begin
            r_elapsed <= r_now - r_starts[pidx];
            r_status  <= sts_pkg::ST_MATCHED;
            r_ptr     <= r_ptr - 1'b1;
        end
        if (i_cmd.shift_step) begin
            r_ids[sts_pkg::OPEN_AW'(r_ptr)]    <= r_ids[pnext];
            r_starts[sts_pkg::OPEN_AW'(r_ptr)] <= r_starts[pnext];
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.stat_read) r_prod <= {32'd0, e32} * {32'd0, e32};
        if (i_cmd.stat_write && id_in) begin
            if (!r_seen[sidx]) begin
                r_cnt[sidx] <= 32'd1;
                r_tot[sidx] <= {16'd0, e32};
                r_min[sidx] <= e32;
                r_max[sidx] <= e32;
                r_sq[sidx]  <= r_prod;
            end else begin
                if (r_cnt[sidx] != '1) r_cnt[sidx] <= r_cnt[sidx] + 1'b1;
                r_tot[sidx] <= (tot_sum < r_tot[sidx]) ? '1 : tot_sum;
                if (r_min[sidx] > e32 || r_min[sidx] == '0) r_min[sidx] <= e32;
                if (r_max[sidx] < e32) r_max[sidx] <= e32;
                r_sq[sidx] <= sq_sum[64] ? '1 : sq_sum[63:0];
            end
        end
        if (i_cmd.emit) begin
            o_status  <= r_status;
            o_echo_id <= r_id;
            o_elapsed <= e32;
            if (id_in && r_seen[sidx]) begin
                o_hit_count   <= r_cnt[sidx];
                o_total_ticks <= r_tot[sidx];
                o_min_ticks   <= r_min[sidx];
                o_max_ticks   <= r_max[sidx];
                o_square_sum  <= r_sq[sidx];
            end else begin
                o_hit_count   <= '0;
                o_total_ticks <= '0;
                o_min_ticks   <= '0;
                o_max_ticks   <= '0;
                o_square_sum  <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/section_timing_statistics.sv
// top level of section timing statistics: controller plus datapath
// depends on sts_pkg, sts_ctrl, sts_dp
//
// channel   ports                                   handshake
// event     i_command i_section_id i_timestamp      i_start && !o_busy
// result    o_status o_echo_id o_elapsed o_* stats  o_valid, one cycle
//
// enter: load, push onto the stack unless full, result strobe
// exit: load, search, on a match compaction, stats read, square,
// stats write, result strobe; search, compaction one entry per cycle
// stats store flags clear at reset, no clearing pass
// results cannot be stalled; o_busy stays high through the strobe cycle
`timescale 1ns / 1ps
`default_nettype none
module section_timing_statistics (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire         i_command,
    input  wire  [3:0]  i_section_id,
    input  wire  [31:0] i_timestamp,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_echo_id,
    output logic [31:0] o_elapsed,
    output logic [31:0] o_hit_count,
    output logic [47:0] o_total_ticks,
    output logic [31:0] o_min_ticks,
    output logic [31:0] o_max_ticks,
    output logic [63:0] o_square_sum
);
    sts_pkg::t_cmd    cmd;
    sts_pkg::t_status stat;
    logic             ctrl_busy;

    sts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start && !o_valid),
        .i_stat(stat), .o_busy(ctrl_busy), .o_cmd(cmd)
    );

    assign o_busy = ctrl_busy || o_valid;

    sts_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_command(i_command), .i_section_id(i_section_id),
        .i_timestamp(i_timestamp), .o_stat(stat), .o_valid(o_valid),
        .o_status(o_status), .o_echo_id(o_echo_id), .o_elapsed(o_elapsed),
        .o_hit_count(o_hit_count), .o_total_ticks(o_total_ticks),
        .o_min_ticks(o_min_ticks), .o_max_ticks(o_max_ticks),
        .o_square_sum(o_square_sum)
    );

`ifndef SYNTHESIS
    a_no_start_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("accept during result beat");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !o_valid) else $error("load during result");
`endif
endmodule
`default_nettype wire
